>>> hdl/riff_wave_chunk_locator_unit_defines.svh
// Assertion macros for the RIFF/WAVE chunk locator.
// Taken by the top level; expects clk and rst_n in scope.
`ifndef RIFF_WAVE_CHUNK_LOCATOR_UNIT_DEFINES_SVH
`define RIFF_WAVE_CHUNK_LOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RWCL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define RWCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hdl/rwcl_pkg.sv
// Shared types and constants of the RIFF/WAVE chunk locator.
// No dependencies; used by rwcl_parse and riff_wave_chunk_locator_unit.
package rwcl_pkg;

    // Little-endian four-character codes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Saturation point of the byte counter
    localparam logic [32:0] POS_MAX = '1;

    // Chunk header length in bytes
    localparam logic [32:0] CHUNK_HDR_BYTES = 33'd8;

    // Header byte positions
    localparam logic [32:0] POS_RIFF_END = 33'd3;
    localparam logic [32:0] POS_LEN_END  = 33'd7;
    localparam logic [32:0] POS_WAVE_END = 33'd11;

    // Verdict codes
    localparam logic [2:0] ST_FOUND       = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF    = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
    localparam logic [2:0] ST_FMT_SHORT   = 3'd3;
    localparam logic [2:0] ST_LIST_ENDED  = 3'd4;
    localparam logic [2:0] ST_STREAM_ENDED = 3'd5;

    localparam logic [7:0] MIN_FMT_RESET = 8'd14;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // Parse context carried from byte to byte
    typedef struct packed {
        phase_t      phase;
        logic [32:0] pos;
        logic [31:0] gather;
        logic [31:0] kind;
        logic [31:0] size;
        logic [32:0] list_end;
        logic [32:0] skip;
        logic        fmt_found;
        logic [31:0] fmt_off;
        logic [31:0] fmt_len;
        logic [31:0] dat_off;
        logic [31:0] dat_len;
    } rwcl_state_t;

    localparam rwcl_state_t STATE_CLEAR = '{
        phase:     PH_HEADER,
        pos:       '0,
        gather:    '0,
        kind:      '0,
        size:      '0,
        list_end:  '0,
        skip:      '0,
        fmt_found: 1'b0,
        fmt_off:   '0,
        fmt_len:   '0,
        dat_off:   '0,
        dat_len:   '0
    };

    // One result of the parser toward the output register
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [31:0] fmt_off;
        logic [31:0] fmt_len;
        logic [31:0] dat_off;
        logic [31:0] dat_len;
    } rwcl_result_t;

    // Clamp a body offset to 32 bits
    function automatic logic [31:0] offset32(input logic [33:0] v);
        offset32 = (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

>>> hdl/rwcl_parse.sv
// Byte-wise parse engine of the RIFF/WAVE chunk locator.
// Depends on rwcl_pkg; holds the parse context and forms one verdict per file.
module rwcl_parse
    import rwcl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   byte_value,
    input  logic         starts_file,
    input  logic         ends_file,
    input  logic [7:0]   min_format_bytes,
    output rwcl_result_t res
);

    rwcl_state_t state_reg;
    rwcl_state_t state_next;
    rwcl_state_t cur;
    rwcl_state_t nxt;

    logic [31:0] gather;
    logic [32:0] p;
    logic [33:0] body;
    logic [32:0] sk;
    logic [32:0] padded;
    logic [34:0] chunk_end;
    logic        have_verdict;
    logic [2:0]  verdict;

    // Restart the context on the first byte of a file
    assign cur    = starts_file ? STATE_CLEAR : state_reg;
    assign gather = {byte_value, cur.gather[31:8]};
    assign p      = cur.pos;
    assign body   = {1'b0, p} + 34'd1;
    assign sk     = (cur.skip != '0) ? cur.skip - 33'd1 : cur.skip;
    assign padded = ({1'b0, gather} + 33'd1) & ~33'd1;
    assign chunk_end = {1'b0, body} + {2'b00, padded};

    // Next context and verdict for the current byte
    always_comb
    begin
        nxt          = cur;
        have_verdict = 1'b0;
        verdict      = ST_FOUND;
        if (cur.phase != PH_DONE)
        begin
            nxt.gather = gather;
            nxt.pos    = (p == POS_MAX) ? p : p + 33'd1;
            case (cur.phase)
                PH_HEADER:
                begin
                    if (p == POS_RIFF_END)
                    begin
                        nxt.kind = gather;
                    end
                    else if (p == POS_LEN_END)
                    begin
                        nxt.size = gather;
                    end
                    else if (p == POS_WAVE_END)
                    begin
                        if (cur.kind != TAG_RIFF)
                        begin
                            have_verdict = 1'b1;
                            verdict      = ST_NOT_RIFF;
                        end
                        else if (gather != TAG_WAVE)
                        begin
                            have_verdict = 1'b1;
                            verdict      = ST_NOT_WAVE;
                        end
                        else
                        begin
                            nxt.list_end = {1'b0, cur.size} + CHUNK_HDR_BYTES;
                            nxt.phase    = PH_CHUNK;
                            nxt.skip     = CHUNK_HDR_BYTES;
                        end
                    end
                end
                PH_CHUNK:
                begin
                    nxt.skip = sk;
                    if (sk == 33'd4)
                    begin
                        nxt.kind = gather;
                    end
                    else if (sk == '0)
                    begin
                        nxt.size = gather;
                        // Record the first usable format chunk
                        if (cur.kind == TAG_FMT && !cur.fmt_found)
                        begin
                            if (gather < {24'd0, min_format_bytes})
                            begin
                                have_verdict = 1'b1;
                                verdict      = ST_FMT_SHORT;
                            end
                            else
                            begin
                                nxt.fmt_found = 1'b1;
                                nxt.fmt_off   = offset32(body);
                                nxt.fmt_len   = gather;
                                if (cur.dat_off != '0 && cur.dat_len != '0)
                                begin
                                    have_verdict = 1'b1;
                                    verdict      = ST_FOUND;
                                end
                            end
                        end
                        // Record a data chunk while none with a size is held
                        else if (cur.kind == TAG_DATA &&
                                 (cur.dat_off == '0 || cur.dat_len == '0))
                        begin
                            nxt.dat_off = offset32(body);
                            nxt.dat_len = gather;
                            if (cur.fmt_found)
                            begin
                                have_verdict = 1'b1;
                                verdict      = ST_FOUND;
                            end
                        end
                        // Skip the padded body, or stop at the list end
                        if (!have_verdict)
                        begin
                            if (chunk_end >= {2'b00, cur.list_end})
                            begin
                                have_verdict = 1'b1;
                                verdict      = ST_LIST_ENDED;
                            end
                            else if (padded != '0)
                            begin
                                nxt.phase = PH_SKIP;
                                nxt.skip  = padded;
                            end
                            else
                            begin
                                nxt.phase = PH_CHUNK;
                                nxt.skip  = CHUNK_HDR_BYTES;
                            end
                        end
                    end
                end
                default:
                begin
                    if (sk == '0)
                    begin
                        nxt.phase = PH_CHUNK;
                        nxt.skip  = CHUNK_HDR_BYTES;
                    end
                    else
                    begin
                        nxt.skip = sk;
                    end
                end
            endcase
            if (!have_verdict && ends_file)
            begin
                have_verdict = 1'b1;
                verdict      = ST_STREAM_ENDED;
            end
            if (have_verdict)
            begin
                nxt.phase = PH_DONE;
            end
        end
    end

    // Result of the current byte
    always_comb
    begin
        res.valid   = have_verdict;
        res.status  = verdict;
        res.fmt_off = nxt.fmt_off;
        res.fmt_len = nxt.fmt_len;
        res.dat_off = nxt.dat_off;
        res.dat_len = nxt.dat_len;
    end

    // Advance the context only on a processed byte
    assign state_next = fire ? nxt : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/riff_wave_chunk_locator_unit.sv
// Top level of the RIFF/WAVE chunk locator: input register, parse engine, result register.
// Depends on rwcl_pkg, rwcl_parse and riff_wave_chunk_locator_unit_defines.svh.
//
//   channel   direction   handshake           payload
//   in        to block    in_valid/in_stall   byte_value, starts_file, ends_file
//   out       from block  out_valid/out_stall status, format/data offset and length
//   cfg       to block    cfg_we              cfg_wdata (min_format_bytes)
//
// One byte per cycle unless the result stalls; a transaction waits in the input register,
// and its verdict, if any, enters the result register as the byte is processed.
// Throughput is set by the single parse step between the two registers.
// Reset clears the parse context and sets min_format_bytes to 14; no clearing pass.
// A stalled result holds the parse step, which backs up into in_stall.
`include "riff_wave_chunk_locator_unit_defines.svh"

module riff_wave_chunk_locator_unit
    import rwcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        starts_file,
    input  logic        ends_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] format_offset,
    output logic [31:0] format_length,
    output logic [31:0] data_offset,
    output logic [31:0] data_length,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    logic         in_sf_reg, in_sf_next;
    logic         in_ef_reg, in_ef_next;
    logic         out_valid_reg, out_valid_next;
    rwcl_result_t out_res_reg, out_res_next;
    logic [7:0]   min_fmt_reg, min_fmt_next;

    logic         in_take;
    logic         out_take;
    logic         adv;
    rwcl_result_t res;

    // Process the held byte when the result register can take a verdict
    assign out_take = out_valid_reg && !out_stall;
    assign adv      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    rwcl_parse u_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (adv),
        .byte_value       (in_byte_reg),
        .starts_file      (in_sf_reg),
        .ends_file        (in_ef_reg),
        .min_format_bytes (min_fmt_reg),
        .res              (res)
    );

    // Load the input register on a transaction, drop it once processed
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_sf_next    = in_sf_reg;
        in_ef_next    = in_ef_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = byte_value;
            in_sf_next    = starts_file;
            in_ef_next    = ends_file;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Capture a verdict, release it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (adv && res.valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration write
    assign min_fmt_next = cfg_we ? cfg_wdata : min_fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_fmt_reg   <= MIN_FMT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            min_fmt_reg   <= min_fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_sf_reg   <= in_sf_next;
        in_ef_reg   <= in_ef_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign format_offset = out_res_reg.fmt_off;
    assign format_length = out_res_reg.fmt_len;
    assign data_offset   = out_res_reg.dat_off;
    assign data_length   = out_res_reg.dat_len;

    // Checks
    `RWCL_ASSERT_NOW(a_stall_needs_item, !in_valid_reg, !in_stall)
    `RWCL_ASSERT_NEXT(a_verdict_shown, adv && res.valid, out_valid)
    `RWCL_ASSERT_NEXT(a_taken_clears, out_take && !(adv && res.valid), !out_valid)
    `RWCL_ASSERT_NOW(a_status_code, out_valid, status <= ST_STREAM_ENDED)

endmodule
